FILE: hw/rtl/base62_id_decoder_macros.svh
// assertion macros for the base62 id decoder
// expects clk_i and rst_ni in the scope of use
`ifndef BASE62_ID_DECODER_MACROS_SVH
`define BASE62_ID_DECODER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define B62D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define B62D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/b62d_pkg.sv
// shared types and constants of the base62 id decoder
// no dependencies
package b62d_pkg;

  localparam int unsigned SYM_W      = 8;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned ACC_W      = 128;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned RUN_LENGTH = 22;
  localparam int unsigned POS_W      = 5;

  // digit values of the largest 128-bit id, most significant first
  localparam logic [DIGIT_W-1:0] MAX_DIGITS [RUN_LENGTH] = '{
    6'd7,  6'd49, 6'd4,  6'd2,  6'd13, 6'd16, 6'd22, 6'd5,  6'd29, 6'd41, 6'd47,
    6'd46, 6'd9,  6'd49, 6'd8,  6'd48, 6'd55, 6'd7,  6'd15, 6'd43, 6'd38, 6'd7
  };

  // running comparison of the digit string against the maximum
  typedef enum logic [1:0] {
    CMP_EQUAL   = 2'd0,
    CMP_LESS    = 2'd1,
    CMP_GREATER = 2'd2
  } cmp_e;

  // decoded character
  typedef struct packed {
    logic               bad;
    logic [DIGIT_W-1:0] digit;
  } char_info_t;

endpackage

FILE: hw/rtl/b62d_char_decode.sv
// maps one ascii character to its base62 digit value
// depends on b62d_pkg
module b62d_char_decode
  import b62d_pkg::*;
(
  input  logic [SYM_W-1:0] symbol_i,
  output char_info_t       info_o
);

  localparam logic [SYM_W-1:0] CH_DIGIT_LO = 8'h30;
  localparam logic [SYM_W-1:0] CH_DIGIT_HI = 8'h39;
  localparam logic [SYM_W-1:0] CH_LOWER_LO = 8'h61;
  localparam logic [SYM_W-1:0] CH_LOWER_HI = 8'h7a;
  localparam logic [SYM_W-1:0] CH_UPPER_LO = 8'h41;
  localparam logic [SYM_W-1:0] CH_UPPER_HI = 8'h5a;
  // offsets that bring each range onto its digit values
  localparam logic [SYM_W-1:0] OFS_LOWER   = 8'h57;
  localparam logic [SYM_W-1:0] OFS_UPPER   = 8'h1d;

  logic [SYM_W-1:0] diff;

  // range check and offset, anything else is a bad character with digit zero
  always_comb begin
    diff        = '0;
    info_o.bad  = 1'b0;
    priority if (symbol_i >= CH_DIGIT_LO && symbol_i <= CH_DIGIT_HI) begin
      diff = symbol_i - CH_DIGIT_LO;
    end else if (symbol_i >= CH_LOWER_LO && symbol_i <= CH_LOWER_HI) begin
      diff = symbol_i - OFS_LOWER;
    end else if (symbol_i >= CH_UPPER_LO && symbol_i <= CH_UPPER_HI) begin
      diff = symbol_i - OFS_UPPER;
    end else begin
      info_o.bad = 1'b1;
    end
    info_o.digit = diff[DIGIT_W-1:0];
  end

endmodule

FILE: hw/rtl/b62d_mac.sv
// 128-bit multiply by 62 and add of one digit, modulo 2^128
// depends on b62d_pkg
module b62d_mac
  import b62d_pkg::*;
(
  input  logic [ACC_W-1:0]   acc_i,
  input  logic [DIGIT_W-1:0] digit_i,
  output logic [ACC_W-1:0]   acc_o
);

  logic [ACC_W-1:0] times64;
  logic [ACC_W-1:0] times2;

  // x*62 = x*64 - x*2, then the digit goes in at the bottom
  assign times64 = acc_i << 6;
  assign times2  = acc_i << 1;
  assign acc_o   = times64 - times2 + {{(ACC_W-DIGIT_W){1'b0}}, digit_i};

endmodule

FILE: hw/rtl/base62_id_decoder.sv
// top level of the base62 id decoder: input register, digit accumulator, result register
// depends on b62d_pkg, b62d_char_decode, b62d_mac and base62_id_decoder_macros.svh
//
// usage
//   the input channel (in_valid_i, in_stall_o, symbol_i) takes ascii characters,
//   most significant first, in runs of exactly 22. each run yields one transaction
//   on the output channel (out_valid_o, out_stall_i, id_high_o, id_low_o, ok_o).
//   ok_o is low when a character outside 0-9, a-z, A-Z was seen or the value is
//   above 2^128-1; the id fields are then zero.
// timing
//   one character per cycle sustained unless out_stall_i holds a result back;
//   runs may follow each other with no gap. an accepted character is held in
//   the input register and then folded into the 128-bit accumulator; a run's
//   result is registered as its 22nd character leaves the input register. the
//   path between registers is the 128-bit shift, subtract and add of the multiply by 62.
// back-pressure
//   while a result waits under out_stall_i, characters still enter and are
//   folded in; only the last character of the next run is held, and in_stall_o
//   rises once the input register holds it.
// reset
//   rst_ni clears the accumulator, the position, the flags and both valids;
//   any partial run is dropped.
`include "base62_id_decoder_macros.svh"

module base62_id_decoder
  import b62d_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SYM_W-1:0]  symbol_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [HALF_W-1:0] id_high_o,
  output logic [HALF_W-1:0] id_low_o,
  output logic              ok_o
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(RUN_LENGTH - 1);

  // input register
  logic             s1_valid_q;
  logic [SYM_W-1:0] sym_q;

  // run state
  logic [ACC_W-1:0] acc_q,  acc_d;
  logic [POS_W-1:0] pos_q,  pos_d;
  logic             bad_q,  bad_d;
  cmp_e             cmp_q,  cmp_d;

  // result register
  logic              out_valid_q;
  logic [HALF_W-1:0] id_high_q, id_low_q;
  logic              ok_q;

  char_info_t       info;
  logic [ACC_W-1:0] acc_next;
  logic             s1_last;
  logic             out_free;
  logic             s1_adv;
  logic             s1_load;
  logic             res_ok;

  // character decode and accumulate
  b62d_char_decode u_char_decode (
    .symbol_i (sym_q),
    .info_o   (info)
  );

  b62d_mac u_mac (
    .acc_i   (acc_q),
    .digit_i (info.digit),
    .acc_o   (acc_next)
  );

  // handshake between the stages
  assign s1_last    = (pos_q == LAST_POS);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_last || out_free);
  assign s1_load    = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !s1_adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      sym_q <= symbol_i;
    end
  end

  // next run state: flags, comparison against the maximum, position
  always_comb begin
    bad_d = bad_q || info.bad;
    cmp_d = cmp_q;
    if (!info.bad && cmp_q == CMP_EQUAL) begin
      priority if (info.digit > MAX_DIGITS[pos_q]) begin
        cmp_d = CMP_GREATER;
      end else if (info.digit < MAX_DIGITS[pos_q]) begin
        cmp_d = CMP_LESS;
      end
    end
    acc_d  = acc_next;
    pos_d  = pos_q + POS_W'(1);
    res_ok = !bad_d && (cmp_d != CMP_GREATER);
    // end of run returns everything to its reset value
    if (s1_last) begin
      acc_d = '0;
      pos_d = '0;
      bad_d = 1'b0;
      cmp_d = CMP_EQUAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
      bad_q <= 1'b0;
      cmp_q <= CMP_EQUAL;
    end else if (s1_adv) begin
      acc_q <= acc_d;
      pos_q <= pos_d;
      bad_q <= bad_d;
      cmp_q <= cmp_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last) begin
      id_high_q <= res_ok ? acc_next[ACC_W-1:HALF_W] : '0;
      id_low_q  <= res_ok ? acc_next[HALF_W-1:0]     : '0;
      ok_q      <= res_ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign id_high_o   = id_high_q;
  assign id_low_o    = id_low_q;
  assign ok_o        = ok_q;

  // checks
  `B62D_ASSERT_NOW(a_fail_zero, out_valid_o && !ok_o, id_high_o == '0 && id_low_o == '0, "failed transaction carries a non-zero id")
  `B62D_ASSERT_NOW(a_stall_holds, in_stall_o, s1_valid_q && s1_last, "input stalled without a held last character")
  `B62D_ASSERT_NOW(a_pos_range, 1'b1, pos_q <= LAST_POS, "position beyond the run length")
  `B62D_ASSERT_NXT(a_run_end, s1_adv && s1_last, out_valid_q && pos_q == '0 && acc_q == '0, "run end did not post a result and clear the state")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// testbench of base62_id_decoder: directed and random 22-character runs
// depends on b62d_pkg and the decoder rtl; ids are predicted in-line and checked per field
module tb;
  import b62d_pkg::*;

  localparam int unsigned ITEMS        = 1560;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // alphabet boundaries
  localparam logic [SYM_W-1:0] CH_0  = "0";
  localparam logic [SYM_W-1:0] CH_9  = "9";
  localparam logic [SYM_W-1:0] CH_LA = "a";
  localparam logic [SYM_W-1:0] CH_LZ = "z";
  localparam logic [SYM_W-1:0] CH_UA = "A";
  localparam logic [SYM_W-1:0] CH_UZ = "Z";

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_LONG
  } stall_mode_e;

  typedef struct packed {
    logic [HALF_W-1:0] id_high;
    logic [HALF_W-1:0] id_low;
    logic              ok;
  } id_result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [SYM_W-1:0]  symbol_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [HALF_W-1:0] id_high_o;
  logic [HALF_W-1:0] id_low_o;
  logic              ok_o;

  // decoder state as predicted
  logic [ACC_W-1:0] id_acc     = '0;
  int unsigned      run_pos    = 0;
  logic             run_bad    = 1'b0;
  cmp_e             run_cmp    = CMP_EQUAL;
  id_result_t       id_expected_q[$];

  int unsigned errors        = 0;
  int unsigned chars_sent    = 0;
  int unsigned ids_checked   = 0;
  int unsigned ids_ok        = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  bit          sender_gaps   = 1'b1;
  stall_mode_e stall_mode    = STALL_NONE;
  bit          stall_hold    = 1'b0;
  int unsigned stall_run     = 0;

  base62_id_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .symbol_i    (symbol_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .id_high_o   (id_high_o),
    .id_low_o    (id_low_o),
    .ok_o        (ok_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    case (stall_mode)
      STALL_NONE: begin
        out_stall_i <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (stall_run == 0) begin
          stall_hold = !stall_hold;
          stall_run  = stall_hold ? $urandom_range(1, 30) : $urandom_range(1, 6);
        end
        stall_run--;
        out_stall_i <= stall_hold;
      end
    endcase
  end

  // check the result first, then fold in the accepted character
  always @(posedge clk_i) begin : monitor
    char_info_t info;
    id_result_t exp_id;
    logic       run_ok;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        ids_checked++;
        if (id_expected_q.size() == 0) begin
          $error("unexpected id transaction: id_high %h id_low %h ok %b",
                 id_high_o, id_low_o, ok_o);
          errors++;
        end else begin
          exp_id = id_expected_q.pop_front();
          if (id_high_o !== exp_id.id_high) begin
            $error("id_high: expected %h, actual %h", exp_id.id_high, id_high_o);
            errors++;
          end
          if (id_low_o !== exp_id.id_low) begin
            $error("id_low: expected %h, actual %h", exp_id.id_low, id_low_o);
            errors++;
          end
          if (ok_o !== exp_id.ok) begin
            $error("ok: expected %b, actual %b", exp_id.ok, ok_o);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        chars_sent++;
        // map the character onto its digit
        info.bad   = 1'b0;
        info.digit = '0;
        if (symbol_i >= CH_0 && symbol_i <= CH_9) begin
          info.digit = DIGIT_W'(symbol_i - CH_0);
        end else if (symbol_i >= CH_LA && symbol_i <= CH_LZ) begin
          info.digit = DIGIT_W'(symbol_i - CH_LA + 8'd10);
        end else if (symbol_i >= CH_UA && symbol_i <= CH_UZ) begin
          info.digit = DIGIT_W'(symbol_i - CH_UA + 8'd36);
        end else begin
          info.bad = 1'b1;
        end
        // a bad character leaves the comparison alone and adds nothing
        if (info.bad) begin
          run_bad = 1'b1;
        end else if (run_cmp == CMP_EQUAL) begin
          if (info.digit > MAX_DIGITS[run_pos]) begin
            run_cmp = CMP_GREATER;
          end else if (info.digit < MAX_DIGITS[run_pos]) begin
            run_cmp = CMP_LESS;
          end
        end
        id_acc = id_acc * 128'd62 + ACC_W'(info.digit);
        if (run_pos + 1 < RUN_LENGTH) begin
          run_pos++;
        end else begin
          run_ok          = !run_bad && (run_cmp != CMP_GREATER);
          exp_id.id_high  = run_ok ? id_acc[ACC_W-1:HALF_W] : '0;
          exp_id.id_low   = run_ok ? id_acc[HALF_W-1:0] : '0;
          exp_id.ok       = run_ok;
          if (run_ok) ids_ok++;
          id_expected_q.push_back(exp_id);
          id_acc  = '0;
          run_pos = 0;
          run_bad = 1'b0;
          run_cmp = CMP_EQUAL;
        end
      end
    end
  end

  function automatic logic [SYM_W-1:0] digit_char(input int d);
    if (d < 10) return CH_0 + SYM_W'(d);
    if (d < 36) return CH_LA + SYM_W'(d - 10);
    return CH_UA + SYM_W'(d - 36);
  endfunction

  // one character transaction, with random gaps between bursts
  task automatic send_symbol(input logic [SYM_W-1:0] sym);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        symbol_i   <= SYM_W'($urandom_range(0, 255));
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    symbol_i   <= sym;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_symbol(s[i]);
    end
  endtask

  // the maximum id, zero, a value just below the maximum and a mixed-case digit string
  task automatic test_boundary_ids();
    stall_mode  = STALL_NONE;
    sender_gaps = 1'b0;
    send_string("7N42dgm5tFLK9N8MT7fHC7");
    send_string("0000000000000000000000");
    sender_gaps = 1'b1;
    stall_mode  = STALL_RANDOM;
    send_string("7N42dgm5tFLK9N8MT7fHC6");
    send_string("0009azAZ09azAZ09azAZ9Z");
  endtask

  // digit strings above the maximum
  task automatic test_over_range();
    stall_mode = STALL_LONG;
    send_string("7N42dgm5tFLK9N8MT7fHC8");
    send_string("8000000000000000000000");
    send_string("ZZZZZZZZZZZZZZZZZZZZZZ");
    send_string("7N42dgm5tFLK9N8MT7fHD0");
  endtask

  // characters outside the alphabet at every kind of boundary
  task automatic test_bad_characters();
    logic [SYM_W-1:0] bad_chars [10] = '{
      8'h00, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h7F, 8'h80, 8'hFF
    };
    stall_mode = STALL_RANDOM;
    for (int i = 0; i < RUN_LENGTH; i++) begin
      send_symbol((i % 2 == 0 && i / 2 < 10) ? bad_chars[i / 2] : digit_char(MAX_DIGITS[i]));
    end
    // bad last character on an otherwise maximal string
    for (int i = 0; i < RUN_LENGTH; i++) begin
      send_symbol(i == RUN_LENGTH - 1 ? 8'hFF : digit_char(MAX_DIGITS[i]));
    end
    repeat (RUN_LENGTH) send_symbol(8'h00);
  endtask

  // mostly well-formed runs, many tracking the maximum, plus noisy ones
  task automatic test_random_runs();
    int unsigned sent;
    int unsigned runs;
    int unsigned kind;
    int unsigned prefix_len;
    int          d;
    logic [SYM_W-1:0] sym;
    sent = 0;
    runs = 0;
    while (sent < ITEMS) begin
      if (runs % 10 == 0) begin
        stall_mode  = stall_mode_e'($urandom_range(0, 2));
        sender_gaps = ($urandom_range(0, 3) != 0);
      end
      kind       = $urandom_range(0, 99);
      prefix_len = $urandom_range(0, RUN_LENGTH);
      for (int i = 0; i < RUN_LENGTH; i++) begin
        if (kind < 35 && i < prefix_len) begin
          sym = digit_char(MAX_DIGITS[i]);
        end else if (kind < 35 && i == prefix_len) begin
          // step just off the maximum at this position
          d = int'(MAX_DIGITS[i]) + int'($urandom_range(0, 2)) - 1;
          if (d < 0) d = 0;
          if (d > 61) d = 61;
          sym = digit_char(d);
        end else if (kind < 75) begin
          sym = digit_char($urandom_range(0, 61));
        end else if (kind < 92) begin
          sym = ($urandom_range(0, 15) == 0) ? SYM_W'($urandom_range(0, 255))
                                             : digit_char($urandom_range(0, 61));
        end else begin
          sym = SYM_W'($urandom_range(0, 255));
        end
        send_symbol(sym);
        sent++;
      end
      runs++;
    end
  endtask

  // main sequence
  initial begin
    int unsigned waited;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_boundary_ids();
    test_over_range();
    test_bad_characters();
    test_random_runs();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    stall_mode  = STALL_NONE;
    // drain outstanding ids
    waited = 0;
    while (id_expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (id_expected_q.size() != 0) begin
      $error("%0d expected ids never arrived", id_expected_q.size());
      errors++;
    end
    $display("summary: %0d characters in, %0d ids out (%0d valid, %0d rejected), %0d errors",
             chars_sent, ids_checked, ids_ok, ids_checked - ids_ok, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
